>>> design/fpu_pkg.sv
`default_nettype none

package fpu_pkg;

    localparam int PARTICLES = 16384;
    localparam int IDX_W     = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
    localparam int SLOT_W    = 14;

    localparam logic CMD_SPAWN   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    localparam logic [2:0] BAND_RED    = 3'd0;
    localparam logic [2:0] BAND_ORANGE = 3'd1;
    localparam logic [2:0] BAND_YELLOW = 3'd2;
    localparam logic [2:0] BAND_CYAN   = 3'd3;
    localparam logic [2:0] BAND_WHITE  = 3'd4;

    localparam logic signed [17:0] LIFE_ONE  = 18'sd65536;
    localparam logic signed [17:0] TH_RED    = 18'sd26214;
    localparam logic signed [17:0] TH_ORANGE = 18'sd39322;
    localparam logic signed [17:0] TH_YELLOW = 18'sd52429;
    localparam logic signed [17:0] TH_CYAN   = 18'sd58982;

    localparam logic signed [31:0] FORCE_Y   = 32'sd2621;
    localparam logic signed [31:0] NUDGE_POS = 32'sd52;
    localparam logic signed [31:0] NUDGE_NEG = -32'sd52;

    // reciprocals for the exact divisions by 25 and by 625
    localparam logic [21:0] VEL_RECIP  = 22'd2684355;
    localparam int          VEL_SHIFT  = 26;
    localparam logic [20:0] FADE_RECIP = 21'd1717987;
    localparam int          FADE_SHIFT = 30;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] force_x;
        logic signed [31:0] force_z;
        logic signed [17:0] life;
        logic        [11:0] fade;
    } t_part;

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = $signed({a[31], a}) + $signed({b[31], b});
        if (s[32] != s[31]) begin
            return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return s[31:0];
    endfunction

    // round(|d| * 32768 / 25) with the sign of d
    function automatic logic signed [31:0] vel_from(input logic signed [6:0] d);
        logic [5:0]  m;
        logic [20:0] x;
        logic [42:0] p;
        logic [31:0] v;
        m = d[6] ? 6'(-d) : d[5:0];
        x = {m, 15'd0} + 21'd12;
        p = 43'(x) * 43'(VEL_RECIP);
        v = 32'(p >> VEL_SHIFT);
        return d[6] ? $signed(-v) : $signed(v);
    endfunction

    // round((100 + r) * 8192 / 625)
    function automatic logic [11:0] fade_from(input logic [6:0] r);
        logic [20:0] x;
        logic [41:0] p;
        x = {(8'(r) + 8'd100), 13'd0} + 21'd312;
        p = 42'(x) * 42'(FADE_RECIP);
        return 12'(p >> FADE_SHIFT);
    endfunction

    function automatic logic [2:0] band_of(input logic signed [17:0] life);
        priority if (life < TH_RED) begin
            return BAND_RED;
        end else if (life < TH_ORANGE) begin
            return BAND_ORANGE;
        end else if (life < TH_YELLOW) begin
            return BAND_YELLOW;
        end else if (life < TH_CYAN) begin
            return BAND_CYAN;
        end else begin
            return BAND_WHITE;
        end
    endfunction

endpackage

`default_nettype wire

>>> design/fpu_ram.sv
`default_nettype none

module fpu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_waddr,
    input  wire logic [WIDTH-1:0]                              i_wdata,
    input  wire logic                                          i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_raddr,
    output logic      [WIDTH-1:0]                              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old word on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> design/fire_particle_update.sv
// Fire particle store with a one-frame Euler update per request.
// Input channel: i_valid / o_stall with i_cmd (spawn or advance), i_slot and
// the random fields. A request is taken at a clock edge with i_valid high and
// o_stall low. Output channel: o_valid / i_stall, one result per request, in
// request order.
// o_valid rises once the request has passed a registered read of the entry
// store with the force update, then the velocity stage, then the position
// stage feeding the output register, where the entry is written back.
// Throughput is one request per cycle for distinct slots while the receiver
// keeps up. A request whose slot is still in one of the three update stages
// is held off with o_stall until that entry has been written back, so
// back-to-back requests to one slot never overlap in the pipeline.
// Reset clears the valid bits of the pipeline and of the output register; the
// store is not cleared, an entry must be spawned before it is advanced.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// o_stall rises in the same cycle; nothing is dropped or repeated.
`default_nettype none

module fire_particle_update
    import fpu_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic                  i_cmd,
    input  wire logic [SLOT_W-1:0]     i_slot,
    input  wire logic [6:0]            i_rnd_fade,
    input  wire logic [5:0]            i_rnd_vx,
    input  wire logic [4:0]            i_rnd_vy,
    input  wire logic [5:0]            i_rnd_vz,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [SLOT_W-1:0]          o_out_slot,
    output logic signed [31:0]         o_px,
    output logic signed [31:0]         o_py,
    output logic signed [31:0]         o_pz,
    output logic [2:0]                 o_colour_band,
    output logic                       o_respawned
);

    logic en;
    logic hazard;
    logic accept;

    // stage 1: store read in flight
    logic              r_s1_valid;
    logic              r_s1_cmd;
    logic [SLOT_W-1:0] r_s1_slot;
    logic [6:0]        r_s1_rnd_fade;
    logic [5:0]        r_s1_rnd_vx;
    logic [4:0]        r_s1_rnd_vy;
    logic [5:0]        r_s1_rnd_vz;

    // stage 2: life and force done
    logic               r_s2_valid;
    logic               r_s2_upd;
    logic [SLOT_W-1:0]  r_s2_slot;
    logic signed [17:0] r_s2_life;
    logic [11:0]        r_s2_fade;
    logic signed [31:0] r_s2_fx, r_s2_fz;
    logic signed [31:0] r_s2_px, r_s2_py, r_s2_pz;
    logic signed [31:0] r_s2_vx, r_s2_vy, r_s2_vz;
    logic [11:0]        r_s2_sp_fade;
    logic signed [31:0] r_s2_sp_vx, r_s2_sp_vy, r_s2_sp_vz;

    // stage 3: velocity done, spawn values merged
    logic               r_s3_valid;
    logic               r_s3_upd;
    logic [SLOT_W-1:0]  r_s3_slot;
    logic signed [17:0] r_s3_life;
    logic [11:0]        r_s3_fade;
    logic signed [31:0] r_s3_fx, r_s3_fz;
    logic signed [31:0] r_s3_px, r_s3_py, r_s3_pz;
    logic signed [31:0] r_s3_vx, r_s3_vy, r_s3_vz;
    logic [2:0]         r_s3_band;

    // output register
    logic               r_out_valid;
    logic [SLOT_W-1:0]  r_out_slot;
    logic signed [31:0] r_out_px, r_out_py, r_out_pz;
    logic [2:0]         r_out_band;
    logic               r_out_resp;

    logic [$bits(t_part)-1:0] ram_rdata;
    t_part              rec;
    t_part              wr_rec;

    logic signed [18:0] n_life;
    logic               n_upd;
    logic signed [31:0] n_fx, n_fz;
    logic signed [6:0]  d_vx, d_vy, d_vz;
    logic signed [31:0] n_vx, n_vy, n_vz;
    logic signed [31:0] n_px, n_py, n_pz;

    assign en     = !r_out_valid || !i_stall;
    assign hazard = (r_s1_valid && (IDX_W'(r_s1_slot) == IDX_W'(i_slot)))
                 || (r_s2_valid && (IDX_W'(r_s2_slot) == IDX_W'(i_slot)))
                 || (r_s3_valid && (IDX_W'(r_s3_slot) == IDX_W'(i_slot)));
    assign o_stall = !en || hazard;
    assign accept  = i_valid && !o_stall;

    assign wr_rec.pos_x   = n_px;
    assign wr_rec.pos_y   = n_py;
    assign wr_rec.pos_z   = n_pz;
    assign wr_rec.vel_x   = r_s3_vx;
    assign wr_rec.vel_y   = r_s3_vy;
    assign wr_rec.vel_z   = r_s3_vz;
    assign wr_rec.force_x = r_s3_fx;
    assign wr_rec.force_z = r_s3_fz;
    assign wr_rec.life    = r_s3_life;
    assign wr_rec.fade    = r_s3_fade;

    fpu_ram #(
        .WIDTH ($bits(t_part)),
        .DEPTH (PARTICLES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (en && r_s3_valid),
        .i_waddr (IDX_W'(r_s3_slot)),
        .i_wdata (wr_rec),
        .i_re    (accept),
        .i_raddr (IDX_W'(i_slot)),
        .o_rdata (ram_rdata)
    );

    assign rec = t_part'(ram_rdata);

    // stage 1 logic: age the entry, nudge force toward the origin, form spawn velocity offsets
    always_comb begin
        n_life = $signed({rec.life[17], rec.life}) - $signed({7'd0, rec.fade});
        n_upd  = (r_s1_cmd == CMD_ADVANCE) && (n_life > 19'sd0);
        n_fx   = sat_add(rec.force_x, rec.pos_x[31] ? NUDGE_POS : NUDGE_NEG);
        n_fz   = sat_add(rec.force_z, rec.pos_z[31] ? NUDGE_POS : NUDGE_NEG);
        d_vx   = $signed({1'b0, r_s1_rnd_vx}) - 7'sd25;
        d_vy   = $signed({2'b00, r_s1_rnd_vy});
        d_vz   = $signed({1'b0, r_s1_rnd_vz}) - 7'sd25;
    end

    // stage 2 logic: velocity
    always_comb begin
        n_vx = sat_add(r_s2_vx, r_s2_fx);
        n_vy = sat_add(r_s2_vy, FORCE_Y);
        n_vz = sat_add(r_s2_vz, r_s2_fz);
    end

    // stage 3 logic: position, zero on spawn
    always_comb begin
        n_px = r_s3_upd ? sat_add(r_s3_px, r_s3_vx) : 32'sd0;
        n_py = r_s3_upd ? sat_add(r_s3_py, r_s3_vy) : 32'sd0;
        n_pz = r_s3_upd ? sat_add(r_s3_pz, r_s3_vz) : 32'sd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid  <= accept;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_cmd      <= i_cmd;
            r_s1_slot     <= i_slot;
            r_s1_rnd_fade <= i_rnd_fade;
            r_s1_rnd_vx   <= i_rnd_vx;
            r_s1_rnd_vy   <= i_rnd_vy;
            r_s1_rnd_vz   <= i_rnd_vz;

            r_s2_upd     <= n_upd;
            r_s2_slot    <= r_s1_slot;
            r_s2_life    <= n_life[17:0];
            r_s2_fade    <= rec.fade;
            r_s2_fx      <= n_fx;
            r_s2_fz      <= n_fz;
            r_s2_px      <= rec.pos_x;
            r_s2_py      <= rec.pos_y;
            r_s2_pz      <= rec.pos_z;
            r_s2_vx      <= rec.vel_x;
            r_s2_vy      <= rec.vel_y;
            r_s2_vz      <= rec.vel_z;
            r_s2_sp_fade <= fade_from(r_s1_rnd_fade);
            r_s2_sp_vx   <= vel_from(d_vx);
            r_s2_sp_vy   <= vel_from(d_vy);
            r_s2_sp_vz   <= vel_from(d_vz);

            r_s3_upd  <= r_s2_upd;
            r_s3_slot <= r_s2_slot;
            r_s3_life <= r_s2_upd ? r_s2_life : LIFE_ONE;
            r_s3_fade <= r_s2_upd ? r_s2_fade : r_s2_sp_fade;
            r_s3_fx   <= r_s2_upd ? r_s2_fx : 32'sd0;
            r_s3_fz   <= r_s2_upd ? r_s2_fz : 32'sd0;
            r_s3_px   <= r_s2_px;
            r_s3_py   <= r_s2_py;
            r_s3_pz   <= r_s2_pz;
            r_s3_vx   <= r_s2_upd ? n_vx : r_s2_sp_vx;
            r_s3_vy   <= r_s2_upd ? n_vy : r_s2_sp_vy;
            r_s3_vz   <= r_s2_upd ? n_vz : r_s2_sp_vz;
            r_s3_band <= r_s2_upd ? band_of(r_s2_life) : BAND_WHITE;

            r_out_slot <= r_s3_slot;
            r_out_px   <= n_px;
            r_out_py   <= n_py;
            r_out_pz   <= n_pz;
            r_out_band <= r_s3_band;
            r_out_resp <= !r_s3_upd;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_out_slot    = r_out_slot;
    assign o_px          = r_out_px;
    assign o_py          = r_out_py;
    assign o_pz          = r_out_pz;
    assign o_colour_band = r_out_band;
    assign o_respawned   = r_out_resp;

endmodule

`default_nettype wire

>>> design/fpu_checker.sv
`default_nettype none

module fpu_checker
    import fpu_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_valid,
    input wire logic               o_stall,
    input wire logic               i_cmd,
    input wire logic [SLOT_W-1:0]  i_slot,
    input wire logic               o_valid,
    input wire logic               i_stall,
    input wire logic [SLOT_W-1:0]  o_out_slot,
    input wire logic signed [31:0] o_px,
    input wire logic signed [31:0] o_py,
    input wire logic signed [31:0] o_pz,
    input wire logic [2:0]         o_colour_band,
    input wire logic               o_respawned
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_slot) && $stable(o_px))
        else $error("stalled result changed");

    // a fresh particle sits at the origin and glows white
    a_spawn_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_respawned |-> o_px == 32'sd0 && o_py == 32'sd0 && o_pz == 32'sd0
                                   && o_colour_band == BAND_WHITE)
        else $error("respawn result not at origin or not white");

    // an accepted spawn reaches the output when the receiver keeps up
    a_spawn_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_cmd == CMD_SPAWN) ##1 !i_stall ##1 !i_stall ##1 !i_stall
        |=> o_valid && o_respawned && o_out_slot == $past(i_slot, 4))
        else $error("spawn request lost or late");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind fire_particle_update fpu_checker u_fpu_checker (.*);

`default_nettype wire

>>> bench/particle_checker.sv
`timescale 1ns / 100ps
`default_nettype none

module particle_checker
    import fpu_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_req_valid,
    input  wire logic                  i_req_stall,
    input  wire logic                  i_req_cmd,
    input  wire logic [SLOT_W-1:0]     i_req_slot,
    input  wire logic [6:0]            i_req_rnd_fade,
    input  wire logic [5:0]            i_req_rnd_vx,
    input  wire logic [4:0]            i_req_rnd_vy,
    input  wire logic [5:0]            i_req_rnd_vz,
    input  wire logic                  i_res_valid,
    input  wire logic                  i_res_stall,
    input  wire logic [SLOT_W-1:0]     i_res_slot,
    input  wire logic signed [31:0]    i_res_px,
    input  wire logic signed [31:0]    i_res_py,
    input  wire logic signed [31:0]    i_res_pz,
    input  wire logic [2:0]            i_res_band,
    input  wire logic                  i_res_respawned,
    output int                         o_fail_count,
    output int                         o_pending
);

    localparam int LIFE_FULL    = 65536;
    localparam int GRAVITY      = 2621;
    localparam int PULL         = 52;
    localparam int RED_BELOW    = 26214;
    localparam int ORANGE_BELOW = 39322;
    localparam int YELLOW_BELOW = 52429;
    localparam int CYAN_BELOW   = 58982;

    typedef struct {
        logic [SLOT_W-1:0]  slot;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic [2:0]         band;
        logic               respawned;
    } t_frame;

    logic signed [31:0] spot_x  [PARTICLES];
    logic signed [31:0] spot_y  [PARTICLES];
    logic signed [31:0] spot_z  [PARTICLES];
    logic signed [31:0] drift_x [PARTICLES];
    logic signed [31:0] drift_y [PARTICLES];
    logic signed [31:0] drift_z [PARTICLES];
    logic signed [31:0] push_x  [PARTICLES];
    logic signed [31:0] push_z  [PARTICLES];
    int                 life_left [PARTICLES];
    int                 fade_rate [PARTICLES];

    t_frame frames_due[$];
    int     faults  = 0;
    int     waiting = 0;

    assign o_fail_count = faults;
    assign o_pending    = waiting;

    function automatic logic signed [31:0] clamp_sum(input logic signed [31:0] a,
                                                     input logic signed [31:0] b);
        longint s;
        s = longint'(a) + longint'(b);
        if (s > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end
        if (s < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return s[31:0];
    endfunction

    // 0.02 * d in Q16.16, rounded half away from zero
    function automatic logic signed [31:0] speed_of(input int d);
        int m;
        int v;
        m = (d < 0) ? -d : d;
        v = (m * 32768 + 12) / 25;
        return (d < 0) ? -v : v;
    endfunction

    function automatic void reseed_entry(input int e, input logic [6:0] rf,
                                         input logic [5:0] rvx, input logic [4:0] rvy,
                                         input logic [5:0] rvz);
        spot_x[e]    = '0;
        spot_y[e]    = '0;
        spot_z[e]    = '0;
        life_left[e] = LIFE_FULL;
        fade_rate[e] = ((100 + int'(rf)) * 8192 + 312) / 625;
        drift_x[e]   = speed_of(int'(rvx) - 25);
        drift_y[e]   = speed_of(int'(rvy));
        drift_z[e]   = speed_of(int'(rvz) - 25);
        push_x[e]    = '0;
        push_z[e]    = '0;
    endfunction

    function automatic t_frame predict_frame(input logic cmd, input logic [SLOT_W-1:0] slot,
                                             input logic [6:0] rf, input logic [5:0] rvx,
                                             input logic [4:0] rvy, input logic [5:0] rvz);
        t_frame f;
        int     e;
        int     life;
        e           = int'(slot) % PARTICLES;
        f.slot      = slot;
        f.band      = BAND_WHITE;
        f.respawned = 1'b1;
        life        = life_left[e] - fade_rate[e];
        if (cmd == CMD_ADVANCE && life > 0) begin
            life_left[e] = life;
            // pull x/z force toward the origin
            push_x[e]  = clamp_sum(push_x[e], (spot_x[e] < 0) ? PULL : -PULL);
            push_z[e]  = clamp_sum(push_z[e], (spot_z[e] < 0) ? PULL : -PULL);
            drift_x[e] = clamp_sum(drift_x[e], push_x[e]);
            drift_y[e] = clamp_sum(drift_y[e], GRAVITY);
            drift_z[e] = clamp_sum(drift_z[e], push_z[e]);
            spot_x[e]  = clamp_sum(spot_x[e], drift_x[e]);
            spot_y[e]  = clamp_sum(spot_y[e], drift_y[e]);
            spot_z[e]  = clamp_sum(spot_z[e], drift_z[e]);
            if (life < RED_BELOW) begin
                f.band = BAND_RED;
            end else if (life < ORANGE_BELOW) begin
                f.band = BAND_ORANGE;
            end else if (life < YELLOW_BELOW) begin
                f.band = BAND_YELLOW;
            end else if (life < CYAN_BELOW) begin
                f.band = BAND_CYAN;
            end
            f.respawned = 1'b0;
        end else begin
            reseed_entry(e, rf, rvx, rvy, rvz);
        end
        f.px = spot_x[e];
        f.py = spot_y[e];
        f.pz = spot_z[e];
        return f;
    endfunction

    task automatic note_fault(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        faults++;
    endtask

    task automatic check_field(input string name, input logic [SLOT_W-1:0] slot,
                               input longint got, input longint want);
        if (got != want) begin
            note_fault($sformatf("slot %0d %s got %0d want %0d", slot, name, got, want));
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_frame want;
        if (i_rst_n) begin
            if (i_req_valid && !i_req_stall) begin
                frames_due.push_back(predict_frame(i_req_cmd, i_req_slot, i_req_rnd_fade,
                                                   i_req_rnd_vx, i_req_rnd_vy,
                                                   i_req_rnd_vz));
            end
            if (i_res_valid && !i_res_stall) begin
                if (frames_due.size() == 0) begin
                    note_fault($sformatf("slot %0d result with no request pending",
                                         i_res_slot));
                end else begin
                    want = frames_due.pop_front();
                    check_field("out_slot", want.slot, i_res_slot, want.slot);
                    check_field("px", want.slot, i_res_px, want.px);
                    check_field("py", want.slot, i_res_py, want.py);
                    check_field("pz", want.slot, i_res_pz, want.pz);
                    check_field("colour_band", want.slot, i_res_band, want.band);
                    check_field("respawned", want.slot, i_res_respawned, want.respawned);
                end
            end
        end
        waiting <= frames_due.size();
    end

endmodule

`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
    import fpu_pkg::*;

    localparam int PHASE_ITEMS = 312;
    localparam int HOT_COUNT   = 12;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               req_valid    = 1'b0;
    logic               req_stall;
    logic               req_cmd      = CMD_SPAWN;
    logic [SLOT_W-1:0]  req_slot     = '0;
    logic [6:0]         req_rnd_fade = '0;
    logic [5:0]         req_rnd_vx   = '0;
    logic [4:0]         req_rnd_vy   = '0;
    logic [5:0]         req_rnd_vz   = '0;
    logic               res_valid;
    logic               res_stall    = 1'b0;
    logic [SLOT_W-1:0]  res_slot;
    logic signed [31:0] res_px;
    logic signed [31:0] res_py;
    logic signed [31:0] res_pz;
    logic [2:0]         res_band;
    logic               res_respawned;

    int faults_seen;
    int frames_waiting;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit armed [PARTICLES];
    int hot_slots [HOT_COUNT];

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    fire_particle_update dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (req_valid),
        .o_stall       (req_stall),
        .i_cmd         (req_cmd),
        .i_slot        (req_slot),
        .i_rnd_fade    (req_rnd_fade),
        .i_rnd_vx      (req_rnd_vx),
        .i_rnd_vy      (req_rnd_vy),
        .i_rnd_vz      (req_rnd_vz),
        .o_valid       (res_valid),
        .i_stall       (res_stall),
        .o_out_slot    (res_slot),
        .o_px          (res_px),
        .o_py          (res_py),
        .o_pz          (res_pz),
        .o_colour_band (res_band),
        .o_respawned   (res_respawned)
    );

    particle_checker u_particle_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_req_valid     (req_valid),
        .i_req_stall     (req_stall),
        .i_req_cmd       (req_cmd),
        .i_req_slot      (req_slot),
        .i_req_rnd_fade  (req_rnd_fade),
        .i_req_rnd_vx    (req_rnd_vx),
        .i_req_rnd_vy    (req_rnd_vy),
        .i_req_rnd_vz    (req_rnd_vz),
        .i_res_valid     (res_valid),
        .i_res_stall     (res_stall),
        .i_res_slot      (res_slot),
        .i_res_px        (res_px),
        .i_res_py        (res_py),
        .i_res_pz        (res_pz),
        .i_res_band      (res_band),
        .i_res_respawned (res_respawned),
        .o_fail_count    (faults_seen),
        .o_pending       (frames_waiting)
    );

    always @(posedge clk) begin
        res_stall <= ($urandom_range(99, 0) < recv_idle_pct);
    end

    // hold the request until taken; the entry is armed once a spawn is issued
    task automatic send_request(input logic cmd, input logic [SLOT_W-1:0] slot,
                                input logic [6:0] rf, input logic [5:0] rvx,
                                input logic [4:0] rvy, input logic [5:0] rvz);
        if ($urandom_range(99, 0) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99, 0) < send_idle_pct) @(posedge clk);
        end
        req_valid    <= 1'b1;
        req_cmd      <= cmd;
        req_slot     <= slot;
        req_rnd_fade <= rf;
        req_rnd_vx   <= rvx;
        req_rnd_vy   <= rvy;
        req_rnd_vz   <= rvz;
        if (cmd == CMD_SPAWN) begin
            armed[int'(slot) % PARTICLES] = 1'b1;
        end
        @(posedge clk);
        while (req_stall) @(posedge clk);
    endtask

    task automatic send_random_request();
        logic [6:0]        rf;
        logic [5:0]        rvx;
        logic [4:0]        rvy;
        logic [5:0]        rvz;
        logic [SLOT_W-1:0] slot;
        logic              cmd;
        if ($urandom_range(99, 0) < 80) begin
            rf  = 7'($urandom_range(99, 0));
            rvx = 6'($urandom_range(49, 0));
            rvy = 5'($urandom_range(19, 0));
            rvz = 6'($urandom_range(49, 0));
        end else begin
            rf  = 7'($urandom);
            rvx = 6'($urandom);
            rvy = 5'($urandom);
            rvz = 6'($urandom);
        end
        // mostly a small pool of slots so particles live out their life and respawn
        if ($urandom_range(99, 0) < 85) begin
            slot = SLOT_W'(hot_slots[$urandom_range(HOT_COUNT - 1, 0)]);
        end else begin
            slot = SLOT_W'($urandom);
        end
        if (!armed[int'(slot) % PARTICLES]) begin
            cmd = CMD_SPAWN;
        end else begin
            cmd = ($urandom_range(99, 0) < 90) ? CMD_ADVANCE : CMD_SPAWN;
        end
        send_request(cmd, slot, rf, rvx, rvy, rvz);
    endtask

    task automatic drain_results();
        req_valid <= 1'b0;
        @(posedge clk);
        while (frames_waiting != 0) @(posedge clk);
    endtask

    initial begin
        hot_slots[0] = 0;
        hot_slots[1] = 14'h3FFF;
        hot_slots[2] = 14'h2AAA;
        hot_slots[3] = 14'h1555;
        for (int i = 4; i < HOT_COUNT; i++) begin
            hot_slots[i] = int'($urandom_range(16383, 0));
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 36;
        recv_idle_pct = 66;

        // field extremes, centered velocity, stated maxima and out-of-range randoms
        send_request(CMD_SPAWN, 14'h0000, 7'd0, 6'd0, 5'd0, 6'd0);
        send_request(CMD_SPAWN, 14'h3FFF, 7'h7F, 6'h3F, 5'h1F, 6'h3F);
        send_request(CMD_SPAWN, 14'h2AAA, 7'd99, 6'd49, 5'd19, 6'd49);
        send_request(CMD_SPAWN, 14'h1555, 7'h55, 6'd25, 5'd0, 6'd25);
        // back-to-back advances of one entry
        send_request(CMD_ADVANCE, 14'h0000, 7'd10, 6'd10, 5'd10, 6'd10);
        send_request(CMD_ADVANCE, 14'h0000, 7'd10, 6'd10, 5'd10, 6'd10);
        send_request(CMD_ADVANCE, 14'h0000, 7'd10, 6'd10, 5'd10, 6'd10);
        send_request(CMD_ADVANCE, 14'h3FFF, 7'd0, 6'd0, 5'd0, 6'd0);
        send_request(CMD_ADVANCE, 14'h2AAA, 7'd0, 6'd0, 5'd0, 6'd0);
        send_request(CMD_ADVANCE, 14'h1555, 7'd0, 6'd0, 5'd0, 6'd0);
        // advance right behind its spawn
        send_request(CMD_SPAWN, 14'h0100, 7'd50, 6'd10, 5'd5, 6'd40);
        send_request(CMD_ADVANCE, 14'h0100, 7'd0, 6'd0, 5'd0, 6'd0);
        // spawn over a live entry
        send_request(CMD_SPAWN, 14'h0000, 7'h7F, 6'd0, 5'h1F, 6'h3F);
        send_request(CMD_ADVANCE, 14'h0000, 7'd1, 6'd2, 5'd3, 6'd4);
        drain_results();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 36;
                    recv_idle_pct = 66;
                end
                1: begin
                    send_idle_pct = 66;
                    recv_idle_pct = 36;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_random_request();
            end
            drain_results();
        end

        repeat (16) @(posedge clk);
        @(negedge clk);
        if (faults_seen == 0 && frames_waiting == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
